// ===== rtl/lrrle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrle_pkg
// Types and constants shared by the literal/repeat run-length encoder.
// ----------------------------------------------------------------------------
package lrrle_pkg;

    // Run limit for both literal and total counts
    localparam logic [7:0] RUN_LIMIT    = 8'd255;
    // Header word: literals in bits 7..0, total in bits 15..8
    localparam int         TOTAL_SHIFT  = 8;
    localparam int         OFFSET_W     = 17;   // wrapping header slot
    localparam int         MAX_WORDS    = 3;    // writes caused by one sample

    typedef struct packed {
        logic signed [15:0] sample;
        logic               final_sample;
    } sample_t;

    typedef struct packed {
        logic [15:0] word_offset;
        logic [15:0] word_data;
        logic        is_header;
        logic        stream_done;
        logic        offset_overflow;
    } word_t;

    // Writes caused by one sample, packed from slot 0; count is 0..3 and only nonzero groups are pushed
    typedef struct packed {
        logic [1:0]                count;
        word_t [MAX_WORDS-1:0]     words;
    } cmd_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

// ===== rtl/lrrle_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrle_front
// Takes samples, tracks the open run and builds the writes of each sample.
// ----------------------------------------------------------------------------
module lrrle_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  lrrle_pkg::sample_t    sample_data,
    input  lrrle_pkg::q_status_t  q_status,
    output logic                  push,
    output lrrle_pkg::cmd_t       push_data
);
    import lrrle_pkg::*;

    logic                open_reg, open_next;
    logic                rep_reg, rep_next;
    logic [7:0]          lit_reg, lit_next;
    logic [7:0]          tot_reg, tot_next;
    logic [15:0]         prev_reg, prev_next;
    logic [OFFSET_W-1:0] rso_reg, rso_next;
    logic                ovf_reg, ovf_next;

    logic                accept;
    logic [15:0]         s;
    logic                same, fin;
    logic                opening, broken, lit_add;
    logic                h1_en, l_en, h2_en, full;
    logic [OFFSET_W-1:0] rso_m, rso_c;
    logic [OFFSET_W:0]   lit_pos;
    logic [7:0]          lit_n, tot_n;
    logic                ovf1, ovf2, ovf3;
    logic [1:0]          n;
    cmd_t                cmd;

    assign sample_ready = !q_status.full;
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        s       = $unsigned(sample_data.sample);
        fin     = sample_data.final_sample;
        same    = (s == prev_reg);
        opening = !open_reg;
        broken  = open_reg && rep_reg && !same;
        lit_add = open_reg && !rep_reg && !same;

        // old header when a repeat is broken
        h1_en = broken;
        rso_m = broken ? OFFSET_W'(rso_reg + OFFSET_W'(1) + OFFSET_W'(lit_reg)) : rso_reg;

        // literal write
        l_en    = opening || broken || lit_add;
        lit_pos = {1'b0, rso_m} + (OFFSET_W+1)'(1)
                  + (lit_add ? (OFFSET_W+1)'(lit_reg) : '0);
        lit_n   = (opening || broken) ? 8'd1 : (lit_add ? 8'(lit_reg + 8'd1) : lit_reg);
        tot_n   = (opening || broken) ? 8'd1 : 8'(tot_reg + 8'd1);

        // closing header: run full or end of channel
        full  = (tot_n == RUN_LIMIT);
        h2_en = full || fin;
        rso_c = h2_en ? OFFSET_W'(rso_m + OFFSET_W'(1) + OFFSET_W'(lit_n)) : rso_m;

        ovf1 = ovf_reg | (h1_en & rso_reg[OFFSET_W-1]);
        ovf2 = ovf1 | (l_en & (lit_pos[OFFSET_W:OFFSET_W-1] != 2'b00));
        ovf3 = ovf2 | (h2_en & rso_m[OFFSET_W-1]);

        cmd = '0;
        n   = 2'd0;
        if (h1_en)
        begin
            cmd.words[n] = '{word_offset: rso_reg[15:0],
                             word_data: {tot_reg, lit_reg},
                             is_header: 1'b1, stream_done: 1'b0,
                             offset_overflow: ovf1};
            n = n + 2'd1;
        end
        if (l_en)
        begin
            cmd.words[n] = '{word_offset: lit_pos[15:0], word_data: s,
                             is_header: 1'b0, stream_done: 1'b0,
                             offset_overflow: ovf2};
            n = n + 2'd1;
        end
        if (h2_en)
        begin
            cmd.words[n] = '{word_offset: rso_m[15:0],
                             word_data: {tot_n, lit_n[TOTAL_SHIFT-1:0]},
                             is_header: 1'b1, stream_done: fin,
                             offset_overflow: ovf3};
            n = n + 2'd1;
        end
        cmd.count = n;

        open_next = open_reg;
        rep_next  = rep_reg;
        lit_next  = lit_reg;
        tot_next  = tot_reg;
        prev_next = prev_reg;
        rso_next  = rso_reg;
        ovf_next  = ovf_reg;
        if (accept)
        begin
            if (fin)
            begin
                open_next = 1'b0;
                rep_next  = 1'b0;
                lit_next  = '0;
                tot_next  = '0;
                prev_next = '0;
                rso_next  = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                open_next = !full;
                rep_next  = !full && open_reg && same;
                lit_next  = full ? 8'd0 : lit_n;
                tot_next  = full ? 8'd0 : tot_n;
                prev_next = s;
                rso_next  = rso_c;
                ovf_next  = ovf3;
            end
        end
    end

    assign push      = accept && (cmd.count != 2'd0);
    assign push_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rep_reg  <= 1'b0;
            lit_reg  <= '0;
            tot_reg  <= '0;
            prev_reg <= '0;
            rso_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            rep_reg  <= rep_next;
            lit_reg  <= lit_next;
            tot_reg  <= tot_next;
            prev_reg <= prev_next;
            rso_reg  <= rso_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// ===== rtl/lrrle_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrle_queue
// Small FIFO of per-sample write groups between front and back.
// ----------------------------------------------------------------------------
module lrrle_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lrrle_pkg::cmd_t       push_data,
    input  logic                  pop,
    output lrrle_pkg::q_status_t  q_status,
    output lrrle_pkg::cmd_t       head
);
    import lrrle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_status.valid = (cnt_reg != '0);
    assign head           = mem[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && q_status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/lrrle_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrle_back
// Serializes queued write groups into one registered word per transfer.
// ----------------------------------------------------------------------------
module lrrle_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrrle_pkg::q_status_t  q_status,
    input  lrrle_pkg::cmd_t       head,
    output logic                  pop,
    output logic                  write_valid,
    input  logic                  write_ready,
    output lrrle_pkg::word_t      write_data
);
    import lrrle_pkg::*;

    logic       valid_reg, valid_next;
    word_t      data_reg, data_next;
    logic [1:0] idx_reg, idx_next;
    logic       load, last;

    assign load = q_status.valid && (!valid_reg || write_ready);
    assign last = (idx_reg == 2'(head.count - 2'd1));
    assign pop  = load && last;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = head.words[idx_reg];
            idx_next   = last ? 2'd0 : 2'(idx_reg + 2'd1);
        end
        else if (write_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign write_valid = valid_reg;
    assign write_data  = data_reg;

endmodule

// ===== rtl/literal_repeat_run_length_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_repeat_run_length_encoder_unit
// Literal-then-repeat run-length encoder issuing addressed word writes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                   payload
//  sample   in   sample_valid/sample_ready   sample_t: sample, final_sample
//  write    out  write_valid/write_ready     word_t: offset, data, flags
//
// Throughput: one sample per cycle unless the queue is full; the write port
// issues one word per cycle while write_ready holds. A sample causes 0..3
// writes, so the sustained rate is one sample per cycle while samples average
// at most one write each; the write port sets the limit.
// Reset clears run state, queue pointers and the output valid; no clear pass.
// A stalled write side fills the QUEUE_DEPTH-entry queue, then drops
// sample_ready; the sample side never stalls the write side.
// ----------------------------------------------------------------------------
module literal_repeat_run_length_encoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  lrrle_pkg::sample_t sample_data,
    output logic               write_valid,
    input  logic               write_ready,
    output lrrle_pkg::word_t   write_data
);
    import lrrle_pkg::*;

    // One queue entry holds every write one sample causes, in stream order
    q_status_t q_status;
    logic      push, pop;
    cmd_t      push_data, head;

    // Front: run tracking, literal/header generation, overflow tracking
    lrrle_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    lrrle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_status  (q_status),
        .head      (head)
    );

    // Back: one word per transfer out of the head entry
    lrrle_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .write_valid (write_valid),
        .write_ready (write_ready),
        .write_data  (write_data)
    );

endmodule

// ===== rtl/lrrle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrle_checker
// Port-level checks for the run-length encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lrrle_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input lrrle_pkg::sample_t sample_data,
    input logic               write_valid,
    input logic               write_ready,
    input lrrle_pkg::word_t   write_data
);
    import lrrle_pkg::*;

    logic xfer;
    logic first_reg;   // next write opens a channel
    logic ovf_reg;     // last write carried the overflow flag mid-channel

    assign xfer = write_valid && write_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            ovf_reg   <= 1'b0;
        end
        else if (xfer)
        begin
            first_reg <= write_data.stream_done;
            ovf_reg   <= write_data.offset_overflow && !write_data.stream_done;
        end
    end

    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample_data))
        else $error("sample dropped or changed while stalled");

    a_write_hold: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && !write_ready |=> write_valid && $stable(write_data))
        else $error("write dropped or changed while stalled");

    a_done_header: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && write_data.stream_done |-> write_data.is_header)
        else $error("stream end on a non-header write");

    a_first_literal: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && first_reg |-> !write_data.is_header && write_data.word_offset == 16'd1)
        else $error("channel does not open with a literal at offset 1");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && ovf_reg |-> write_data.offset_overflow)
        else $error("offset overflow flag cleared inside a channel");

endmodule

bind literal_repeat_run_length_encoder_unit lrrle_checker u_lrrle_checker (.*);
